// ===== hdl/wbps_pkg.sv =====
`default_nettype none
package wbps_pkg;

   // Widths fixed by the register map and the request and result fields.
   localparam int DATA_W              = 64;
   localparam int ADDR_W              = 6;
   localparam int LENGTH_W            = 5;
   localparam int PATTERN_FIELD_BYTES = 16;
   localparam int MASK_W              = PATTERN_FIELD_BYTES;

   localparam int MAX_PATTERN_BYTES_DEFAULT = 16;

   // Register indexes, taken from paddr bits 5:3.
   localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
   localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
   localparam logic [2:0] REG_WILDCARD_MASK  = 3'd2;
   localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
   localparam logic [2:0] REG_START_ADDRESS  = 3'd4;

   typedef struct packed {
      logic [2*DATA_W-1:0] pattern;
      logic [MASK_W-1:0]   wildcard_mask;
      logic [LENGTH_W-1:0] pattern_length;
      logic [DATA_W-1:0]   start_address;
   } cfg_type;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] match_address;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/wbps_csr.sv =====
`default_nettype none
module wbps_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [wbps_pkg::ADDR_W-1:0] paddr,
   input  wire logic [wbps_pkg::DATA_W-1:0] pwdata,
   output logic      [wbps_pkg::DATA_W-1:0] prdata,
   output logic                             pready,
   output wbps_pkg::cfg_type                cfg
);
   import wbps_pkg::*;

   logic [DATA_W-1:0]   pattern_low_ff;
   logic [DATA_W-1:0]   pattern_high_ff;
   logic [MASK_W-1:0]   wildcard_mask_ff;
   logic [LENGTH_W-1:0] pattern_length_ff;
   logic [DATA_W-1:0]   start_address_ff;
   logic                write_en;
   logic [2:0]          reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel & penable & pwrite;
   assign reg_index = paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LENGTH_W'(1);
         start_address_ff  <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_PATTERN_LOW:    pattern_low_ff    <= pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= pwdata;
            REG_WILDCARD_MASK:  wildcard_mask_ff  <= pwdata[MASK_W-1:0];
            REG_PATTERN_LENGTH: pattern_length_ff <= pwdata[LENGTH_W-1:0];
            REG_START_ADDRESS:  start_address_ff  <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LOW:    prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   prdata = pattern_high_ff;
         REG_WILDCARD_MASK:  prdata = DATA_W'(wildcard_mask_ff);
         REG_PATTERN_LENGTH: prdata = DATA_W'(pattern_length_ff);
         REG_START_ADDRESS:  prdata = start_address_ff;
         default:            prdata = '0;
      endcase
   end

   assign cfg.pattern        = {pattern_high_ff, pattern_low_ff};
   assign cfg.wildcard_mask  = wildcard_mask_ff;
   assign cfg.pattern_length = pattern_length_ff;
   assign cfg.start_address  = start_address_ff;

endmodule
`default_nettype wire

// ===== hdl/wbps_scan.sv =====
`default_nettype none
module wbps_scan #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wbps_pkg::cfg_type         cfg,
   input  wire logic                 step,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 last_byte,
   output logic                      result_valid,
   output wbps_pkg::result_type      result
);
   import wbps_pkg::*;

   // Only the newest CAP bytes can ever take part in a compare.
   localparam int CAP = (MAX_PATTERN_BYTES < PATTERN_FIELD_BYTES) ?
                        MAX_PATTERN_BYTES : PATTERN_FIELD_BYTES;

   logic [7:0]          window_ff [CAP];
   logic [7:0]          window_in [CAP];
   logic [DATA_W-1:0]   seen_ff;
   logic [DATA_W-1:0]   seen_in;
   logic                done_ff;
   logic                done_in;
   logic [LENGTH_W-1:0] len;
   logic                enough;
   logic                window_ok;
   logic                hit;

   always_comb begin
      if (cfg.pattern_length > LENGTH_W'(CAP)) len = LENGTH_W'(CAP);
      else                                     len = cfg.pattern_length;
   end

   // Window after the new byte is shifted in; entry 0 is the newest.
   always_comb begin
      window_in[0] = data_byte;
      for (int j = 1; j < CAP; j++) window_in[j] = window_ff[j-1];
   end

   assign seen_in = (&seen_ff) ? seen_ff : seen_ff + DATA_W'(1);
   assign enough  = (|seen_in[DATA_W-1:LENGTH_W]) || (seen_in[LENGTH_W-1:0] >= len);

   // Pattern byte k lines up with window entry len-1-k.
   always_comb begin
      logic [7:0] sel;
      window_ok = 1'b1;
      for (int k = 0; k < CAP; k++) begin
         sel = '0;
         for (int j = 0; j < CAP; j++) begin
            if (int'(len) - 1 - k == j) sel = window_in[j];
         end
         if (k < int'(len) && !cfg.wildcard_mask[k] && cfg.pattern[8*k +: 8] != sel)
            window_ok = 1'b0;
      end
   end

   assign hit     = !done_ff && (len != '0) && enough && window_ok;
   assign done_in = last_byte ? 1'b0 : (done_ff | hit);

   assign result_valid = hit | (last_byte & ~done_ff);
   assign result.found = hit;
   assign result.match_address = hit ?
      cfg.start_address + (seen_in - DATA_W'(len)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CAP; j++) window_ff[j] <= '0;
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            for (int j = 0; j < CAP; j++) window_ff[j] <= '0;
            seen_ff <= '0;
         end else begin
            for (int j = 0; j < CAP; j++) window_ff[j] <= window_in[j];
            seen_ff <= seen_in;
         end
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/wildcard_byte_pattern_search_unit.sv =====
`default_nettype none
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+------------------------------------
// request    | in        | req_valid/req_stall| req_data_byte, req_last_byte
// result     | out       | rsp_valid/rsp_stall| rsp_found, rsp_match_address
// registers  | in/out    | APB, pready high   | paddr, pwdata, prdata (64 bits)
//
// One request per cycle is sustained while rsp_stall is low; a request waits in the input
// register and its result, if any, is then captured in the result register.
// The window compare is a parallel combinational check between the two registers.
// Reset is synchronous and clears the scan window, the byte count and all configuration
// registers (pattern_length resets to 1). A stalled result holds the input register, which
// in turn raises req_stall; an empty input register always takes a request.
module wildcard_byte_pattern_search_unit #(
   parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_found,
   output logic      [wbps_pkg::DATA_W-1:0] rsp_match_address,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [wbps_pkg::ADDR_W-1:0] paddr,
   input  wire logic [wbps_pkg::DATA_W-1:0] pwdata,
   output logic      [wbps_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);
   import wbps_pkg::*;

   cfg_type           cfg;
   result_type        result;
   logic              result_valid;

   // Input register: one request waiting for the compare.
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [7:0]        in_data_ff;
   logic              in_last_ff;

   // Result register.
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              out_found_ff;
   logic [DATA_W-1:0] out_address_ff;

   logic              out_free;
   logic              advance;
   logic              accept;

   wbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wbps_scan #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .step         (advance),
      .data_byte    (in_data_ff),
      .last_byte    (in_last_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   // The held request moves on whenever the result register is empty or is
   // being taken this cycle. A request that causes no result still needs this
   // slot, which keeps results in order without any extra bookkeeping.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept)       in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
   end

   always_comb begin
      if (advance)        out_valid_in = result_valid;
      else if (rsp_stall) out_valid_in = out_valid_ff;
      else                out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && result_valid) begin
         out_found_ff   <= result.found;
         out_address_ff <= result.match_address;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_match_address = out_address_ff;

endmodule
`default_nettype wire
